@@ src/sisp_pkg.sv @@
// Shared types, codes and defaults for the server info stream parser.
package sisp_pkg;

  localparam int unsigned STRING_CAP_DEFAULT  = 1023;
  localparam int unsigned OPAQUE_BYTES_DEFAULT = 16;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_MAX_STRING   = 2'd0;
  localparam logic [1:0] CFG_PROTOCOL     = 2'd1;
  localparam logic [1:0] CFG_CLIENT_LIMIT = 2'd2;

  localparam logic [9:0]  MAX_STRING_RESET   = 10'd255;
  localparam logic [31:0] PROTOCOL_RESET     = 32'd48;
  localparam logic [7:0]  CLIENT_LIMIT_RESET = 8'd32;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_CLIENTS,
    PH_SPARE,
    PH_FLAG,
    PH_STRING,
    PH_RESERVED
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_BAD_CONFIG,
    ST_EMPTY,
    ST_TRUNCATED,
    ST_PROTOCOL,
    ST_CLIENTS,
    ST_FLAG,
    ST_INCONSISTENT,
    ST_UNTERMINATED,
    ST_TOO_LONG,
    ST_RESERVED
  } status_t;

  typedef struct packed {
    logic [9:0]  max_string_length;
    logic [31:0] supported_protocol;
    logic [7:0]  client_limit;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  string_number;
    logic [7:0]  character;
    status_t     status;
    logic [15:0] err_offset;
    logic [15:0] consumed_length;
    logic [7:0]  max_clients;
    logic        multi_client;
  } result_t;

endpackage

@@ src/sisp_if.sv @@
// Stream channel interfaces: body bytes in, parse results out.
interface sisp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_body;
  logic       no_data;

  modport source (output valid, data_byte, end_of_body, no_data, input ready);
  modport sink   (input valid, data_byte, end_of_body, no_data, output ready);
endinterface

interface sisp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  string_number;
  logic [7:0]  character;
  logic [3:0]  status;
  logic [15:0] err_offset;
  logic [15:0] consumed_length;
  logic [7:0]  max_clients;
  logic        multi_client;

  modport source (output valid, result_kind, string_number, character, status, err_offset,
                  consumed_length, max_clients, multi_client, input ready);
  modport sink   (input valid, result_kind, string_number, character, status, err_offset,
                  consumed_length, max_clients, multi_client, output ready);
endinterface

@@ src/sisp_cfg.sv @@
// Configuration register file.
module sisp_cfg
  import sisp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_string_length  <= MAX_STRING_RESET;
      cfg.supported_protocol <= PROTOCOL_RESET;
      cfg.client_limit       <= CLIENT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_STRING:   cfg.max_string_length  <= cfg_wdata[9:0];
        CFG_PROTOCOL:     cfg.supported_protocol <= cfg_wdata;
        CFG_CLIENT_LIMIT: cfg.client_limit       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/sisp_parse.sv @@
// Parser state registers and the per-byte decode that forms a result.
module sisp_parse
  import sisp_pkg::*;
#(
  parameter int unsigned STRING_CAP   = STRING_CAP_DEFAULT,
  parameter int unsigned OPAQUE_BYTES = OPAQUE_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_body,
  input  logic       no_data,
  output logic       res_valid,
  output result_t    res
);

  localparam int unsigned PrefixLen = 12 + OPAQUE_BYTES;

  typedef struct packed {
    logic [15:0] pos;
    phase_t      phase;
    logic [23:0] proto;   // protocol bytes 0..2; byte 3 is compared as it arrives
    logic [7:0]  ccount;
    logic        mflag;
    logic [2:0]  sfield;
    logic [9:0]  slen;
    logic        sent;
  } pstate_t;

  pstate_t st, st_next;

  function automatic result_t status_res(status_t code, logic [15:0] off);
    result_t r;
    r = '0;
    r.result_kind  = KIND_STATUS;
    r.status       = code;
    r.err_offset   = off;
    return r;
  endfunction

  // status for a body that ends before a status was given
  function automatic result_t end_res(phase_t ph, logic [15:0] n);
    logic [15:0] off;
    result_t     r;
    if (n < 16'd4)       off = 16'd0;
    else if (n < 16'd8)  off = 16'd4;
    else if (n < 16'd12) off = 16'd8;
    else                 off = 16'd12;
    if (ph == PH_PREFIX)      r = status_res(ST_TRUNCATED, off);
    else if (ph == PH_STRING) r = status_res(ST_UNTERMINATED, n);
    else                      r = status_res(ST_TRUNCATED, n);
    return r;
  endfunction

  logic        cfg_ok;
  logic        at_start;
  logic [15:0] pos_inc;
  logic        done;
  logic [2:0]  sfield_inc;

  assign cfg_ok   = (cfg.max_string_length != 10'd0) &&
                    (32'(cfg.max_string_length) <= 32'(STRING_CAP));
  assign at_start = (st.pos == 16'd0) && (st.phase == PH_PREFIX);
  assign pos_inc  = (st.pos != 16'hFFFF) ? st.pos + 16'd1 : st.pos;
  assign sfield_inc = st.sfield + 3'd1;

  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    done      = 1'b0;
    if (no_data) begin
      if (!st.sent) begin
        res_valid = 1'b1;
        if (at_start) res = status_res(cfg_ok ? ST_EMPTY : ST_BAD_CONFIG, 16'd0);
        else          res = end_res(st.phase, st.pos);
      end
      st_next = '0;
    end else if (st.sent) begin
      if (end_of_body) st_next = '0;
    end else if (at_start && !cfg_ok) begin
      res_valid    = 1'b1;
      res          = status_res(ST_BAD_CONFIG, 16'd0);
      st_next.sent = 1'b1;
      if (end_of_body) st_next = '0;
    end else begin
      st_next.pos = pos_inc;
      unique case (st.phase)
        PH_PREFIX: begin
          if (st.pos[15:2] == 14'd0) begin
            if (st.pos[1:0] == 2'd3) begin
              if ({data_byte, st.proto} != cfg.supported_protocol) begin
                res  = status_res(ST_PROTOCOL, 16'd0);
                done = 1'b1;
              end
            end else begin
              st_next.proto[{st.pos[1:0], 3'b000} +: 8] = data_byte;
            end
          end
          if (!done && st.pos >= 16'(PrefixLen - 1)) st_next.phase = PH_CLIENTS;
        end
        PH_CLIENTS: begin
          if (data_byte == 8'd0 || data_byte > cfg.client_limit) begin
            res  = status_res(ST_CLIENTS, st.pos);
            done = 1'b1;
          end else begin
            st_next.ccount = data_byte;
            st_next.phase  = PH_SPARE;
          end
        end
        PH_SPARE: st_next.phase = PH_FLAG;
        PH_FLAG: begin
          if (data_byte > 8'd1) begin
            res  = status_res(ST_FLAG, st.pos);
            done = 1'b1;
          end else if (data_byte[0] != (st.ccount > 8'd1)) begin
            res  = status_res(ST_INCONSISTENT, st.pos);
            done = 1'b1;
          end else begin
            st_next.mflag  = data_byte[0];
            st_next.phase  = PH_STRING;
            st_next.sfield = 3'd0;
            st_next.slen   = 10'd0;
          end
        end
        PH_STRING: begin
          if (data_byte == 8'd0) begin
            st_next.sfield = sfield_inc;
            st_next.slen   = 10'd0;
            if (sfield_inc >= 3'd4) st_next.phase = PH_RESERVED;
          end else if (st.slen >= cfg.max_string_length) begin
            res  = status_res(ST_TOO_LONG, st.pos);
            done = 1'b1;
          end else begin
            st_next.slen = st.slen + 10'd1;
            if (st.sfield < 3'd3) begin
              res_valid         = 1'b1;
              res.result_kind   = KIND_CHAR;
              res.string_number = st.sfield[1:0];
              res.character     = data_byte;
            end
          end
        end
        PH_RESERVED: begin
          done = 1'b1;
          if (data_byte != 8'd0) begin
            res = status_res(ST_RESERVED, st.pos);
          end else begin
            res                 = status_res(ST_OK, 16'd0);
            res.consumed_length = pos_inc;
            res.max_clients     = st.ccount;
            res.multi_client    = st.mflag;
          end
        end
        default: ;
      endcase
      if (done) begin
        res_valid    = 1'b1;
        st_next.sent = 1'b1;
      end else if (end_of_body) begin
        // a character from the last byte gives way to the end status
        res_valid = 1'b1;
        res       = end_res(st_next.phase, st_next.pos);
      end
      if (end_of_body) st_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st <= '0;
    else if (take) st <= st_next;
  end

endmodule

@@ src/sisp_outreg.sv @@
// Result register driving the output channel.
module sisp_outreg
  import sisp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t d,
  output logic    can_load,
  sisp_out_if.source result
);

  result_t q;

  assign can_load = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (can_load) result.valid <= load;
  end

  always_ff @(posedge clk) begin
    if (can_load && load) q <= d;
  end

  assign result.result_kind     = q.result_kind;
  assign result.string_number   = q.string_number;
  assign result.character       = q.character;
  assign result.status          = q.status;
  assign result.err_offset      = q.err_offset;
  assign result.consumed_length = q.consumed_length;
  assign result.max_clients     = q.max_clients;
  assign result.multi_client    = q.multi_client;

endmodule

@@ src/server_info_stream_parser.sv @@
// Top level of the server info stream parser.
// The parser takes one body byte per cycle and returns at most one result per byte, in the
// cycle after the byte transfer: a string character while strings 0..2 arrive, or a single
// status per body. The per-byte decode sits between the parser state registers and a
// single result register; a byte is taken whenever that register is empty or being drained
// in the same cycle, so the sustained rate is one byte per clock as long as the sink keeps
// up. Characters reach the sink before the body's status is known and must be dropped by
// the sink when that status is an error. Configuration writes are meant for idle periods.
module server_info_stream_parser
  import sisp_pkg::*;
#(
  parameter int unsigned STRING_CAP          = STRING_CAP_DEFAULT,
  parameter int unsigned OPAQUE_BINARY_BYTES = OPAQUE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  sisp_in_if.sink     body,
  sisp_out_if.source  result
);

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    can_load;
  logic    take;

  assign body.ready = can_load;
  assign take       = body.valid && can_load;

  sisp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sisp_parse #(
    .STRING_CAP   (STRING_CAP),
    .OPAQUE_BYTES (OPAQUE_BINARY_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .data_byte   (body.data_byte),
    .end_of_body (body.end_of_body),
    .no_data     (body.no_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  sisp_outreg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && res_valid),
    .d        (res),
    .can_load (can_load),
    .result   (result)
  );

  // a new result only appears after a byte transfer
  a_result_from_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(body.valid && body.ready))
    else $error("result appeared without a byte transfer");

  // a successful status carries the consumed length, a nonzero client count and no error offset
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.result_kind == KIND_STATUS && result.status == ST_OK) |->
    (result.err_offset == 16'd0 && result.consumed_length != 16'd0 &&
     result.max_clients != 8'd0))
    else $error("ok status with inconsistent fields");

  // characters come only from strings 0..2 and carry no status
  a_char_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.result_kind == KIND_CHAR) |->
    (result.status == ST_OK && result.string_number != 2'd3 && result.character != 8'd0))
    else $error("malformed character result");

endmodule
